### sv/bit_record_schema_validator_defines.svh
// Assertion macros shared by the bit record schema validator RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef BIT_RECORD_SCHEMA_VALIDATOR_DEFINES_SVH
`define BIT_RECORD_SCHEMA_VALIDATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BRSV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled during reset
`define BRSV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

### sv/brsv_pkg.sv
// Package for the bit record schema validator: constants, walker types
// and the per-bit walker step functions. Depends on nothing.
package brsv_pkg;

   localparam int MapWalkers = 2;
   localparam int GapWalkers = 7;
   localparam int PhaseCount = 13;

   localparam logic [2:0] FieldCount     = 3'd6;
   localparam logic [5:0] GapFieldBits   = 6'd32;
   localparam logic [5:0] AwaitGap       = 6'd63;
   localparam logic [5:0] MapFixedBits   = 6'd8;
   localparam logic [5:0] MapPresBits    = 6'd8;
   localparam logic [5:0] Opt6Bits       = 6'd36;
   localparam logic [5:0] Opt7ScalarBits = 6'd7;

   localparam logic [3:0] PhRecord     = 4'd0;
   localparam logic [3:0] PhMap        = 4'd1;
   localparam logic [3:0] PhFixed      = 4'd8;
   localparam logic [3:0] PhOpt6       = 4'd9;
   localparam logic [3:0] PhOpt7Flag   = 4'd10;
   localparam logic [3:0] PhOpt7Scalar = 4'd11;
   localparam logic [3:0] PhTrailer    = 4'd12;
   localparam logic [3:0] PhaseDone    = 4'd13;

   localparam logic [7:0] TypeMap       = 8'd1;
   localparam logic [7:0] TypeFixed     = 8'd4;
   localparam logic [7:0] TypeGap       = 8'd23;
   localparam logic [7:0] Type4BodyBits = 8'd165;
   localparam logic [7:0] BitsMax       = 8'd255;

   localparam logic [5:0] OptWidth [6] = '{6'd31, 6'd31, 6'd31, 6'd6, 6'd7, 6'd31};

   typedef enum logic [1:0] {
      ST_ALIVE    = 2'd0,
      ST_COMPLETE = 2'd1,
      ST_FAILED   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      V_MISMATCH    = 3'd0,
      V_UNSUPPORTED = 3'd1,
      V_PREFIX      = 3'd2,
      V_TRAILER     = 3'd3,
      V_MAP_AMBIG   = 3'd4,
      V_GAP         = 3'd5,
      V_GAP_AMBIG   = 3'd6,
      V_PARTIAL     = 3'd7
   } verdict_type;

   typedef struct packed {
      logic [3:0] phase;
      logic [5:0] count;
      logic [7:0] presence;
      status_type status;
   } map_walker_type;

   typedef struct packed {
      logic [2:0] field;
      logic [5:0] count;
      status_type status;
   } gap_walker_type;

   function automatic logic [5:0] phase_len(logic w, logic [3:0] p, logic [7:0] pres);
      logic [3:0] idx;
      logic [5:0] len;
      idx = p - 4'd2;
      len = 6'd0;
      case (p) inside
         PhRecord:      len = w ? 6'd0 : 6'd1;
         PhMap:         len = MapPresBits;
         [4'd2:4'd7]:   len = pres[idx[2:0]] ? OptWidth[idx[2:0]] : 6'd0;
         PhFixed:       len = MapFixedBits;
         PhOpt6:        len = pres[6] ? Opt6Bits : 6'd0;
         PhOpt7Flag:    len = pres[7] ? 6'd1 : 6'd0;
         PhTrailer:     len = w ? 6'd1 : 6'd0;
         default:       len = 6'd0;
      endcase
      return len;
   endfunction

   // enter phase p or the first later phase that needs bits, else complete
   function automatic map_walker_type map_settle(logic w, logic [3:0] p, map_walker_type cur);
      map_walker_type nxt;
      logic [3:0]     q;
      logic [5:0]     len;
      nxt        = cur;
      nxt.phase  = PhaseDone;
      nxt.count  = 6'd0;
      nxt.status = ST_COMPLETE;
      for (int i = PhaseCount - 1; i >= 0; i--) begin
         q   = 4'(i);
         len = phase_len(w, q, cur.presence);
         if (q >= p && len != 6'd0) begin
            nxt.phase  = q;
            nxt.count  = len;
            nxt.status = cur.status;
         end
      end
      return nxt;
   endfunction

   function automatic map_walker_type map_start(logic w);
      map_walker_type cur;
      cur          = '0;
      cur.status   = ST_ALIVE;
      return map_settle(w, PhRecord, cur);
   endfunction

   function automatic map_walker_type map_take(logic w, logic bit_v, map_walker_type cur);
      map_walker_type nxt;
      logic [5:0]     pos;
      logic [5:0]     c;
      nxt = cur;
      pos = MapPresBits - cur.count;
      c   = cur.count - 6'd1;
      if (cur.status == ST_FAILED) begin
         nxt = cur;
      end else if (cur.status == ST_COMPLETE || cur.count == 6'd0) begin
         nxt.status = ST_FAILED;
      end else begin
         if (cur.phase == PhMap && cur.count <= MapPresBits && bit_v)
            nxt.presence[pos[2:0]] = 1'b1;
         if (cur.phase == PhOpt7Flag) begin
            if (bit_v) begin
               nxt.phase = PhOpt7Scalar;
               nxt.count = Opt7ScalarBits;
            end else begin
               nxt = map_settle(w, PhTrailer, nxt);
            end
         end else begin
            nxt.count = c;
            if (c == 6'd0)
               nxt = map_settle(w, cur.phase + 4'd1, nxt);
         end
      end
      return nxt;
   endfunction

   function automatic gap_walker_type gap_advance(logic [2:0] g, gap_walker_type cur);
      gap_walker_type nxt;
      logic [3:0]     f;
      nxt = cur;
      f   = {1'b0, cur.field} + 4'd1;
      if (f >= {1'b0, FieldCount}) begin
         nxt.field = FieldCount;
         if (g == FieldCount) begin
            nxt.count = AwaitGap;
         end else begin
            nxt.count  = 6'd0;
            nxt.status = ST_COMPLETE;
         end
      end else begin
         nxt.field = f[2:0];
         nxt.count = (f[2:0] == g) ? AwaitGap : 6'd0;
      end
      return nxt;
   endfunction

   function automatic gap_walker_type gap_start(logic [2:0] g);
      gap_walker_type nxt;
      nxt.field  = 3'd0;
      nxt.count  = (g == 3'd0) ? AwaitGap : 6'd0;
      nxt.status = ST_ALIVE;
      return nxt;
   endfunction

   function automatic gap_walker_type gap_take(logic [2:0] g, logic bit_v, gap_walker_type cur);
      gap_walker_type nxt;
      logic [5:0]     c;
      nxt = cur;
      c   = cur.count - 6'd1;
      if (cur.status == ST_FAILED) begin
         nxt = cur;
      end else if (cur.status == ST_COMPLETE) begin
         nxt.status = ST_FAILED;
      end else if (cur.count == AwaitGap) begin
         nxt.count = 6'd0;
         if (cur.field >= FieldCount)
            nxt.status = ST_COMPLETE;
      end else if (cur.count == 6'd0) begin
         if (bit_v)
            nxt.count = GapFieldBits;
         else
            nxt = gap_advance(g, cur);
      end else begin
         nxt.count = c;
         if (c == 6'd0)
            nxt = gap_advance(g, nxt);
      end
      return nxt;
   endfunction

endpackage

### sv/bit_record_schema_validator.sv
// Bit record schema validator: walks a record body bit by bit and gives
// one verdict per body. Depends on brsv_pkg and the defines header.
//
// Usage:
//  - Input channel req_*: one body bit per transfer, first bit of the body
//    flagged by req_first_item (which also samples req_record_type and
//    req_range_fault), final transfer flagged by req_last_item. An empty
//    body is one transfer with req_carries_no_bit set.
//  - Result channel rsp_*: one transfer carrying rsp_verdict and
//    rsp_gap_mask for each accepted input transfer with req_last_item set.
//  - The result is registered and valid in the cycle after the last input transfer.
//  - Throughput: one input transfer per cycle unless req_stall holds it; the held
//    type's walkers step in the same cycle from the state registers, feeding the result register.
//  - Stall: while a result waits under rsp_stall, bit transfers keep
//    flowing; only a transfer with req_last_item set is held by req_stall.
//  - Reset (synchronous, active high) clears all walkers, the type, the bit
//    count and the result valid flag; no clearing pass follows.
`include "bit_record_schema_validator_defines.svh"

module bit_record_schema_validator
   import brsv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_body_bit,
   input  logic       req_first_item,
   input  logic       req_last_item,
   input  logic       req_carries_no_bit,
   input  logic [7:0] req_record_type,
   input  logic       req_range_fault,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_verdict,
   output logic [6:0] rsp_gap_mask
);

   logic           req_accept;
   logic [7:0]     held_type_ff, held_type_in;
   logic [7:0]     bits_seen_ff, bits_seen_in;
   logic           fault_seen_ff, fault_seen_in;
   map_walker_type map_ff [MapWalkers];
   map_walker_type map_in [MapWalkers];
   gap_walker_type gap_ff [GapWalkers];
   gap_walker_type gap_in [GapWalkers];
   logic [6:0]     mask_in;
   verdict_type    verdict_in;
   logic           rsp_valid_ff, rsp_valid_in;
   verdict_type    rsp_verdict_ff;
   logic [6:0]     rsp_gap_mask_ff;
   logic           pre_ok, trl_ok;
   logic           rsp_hold, last_accept, first_accept;
   logic           rsp_is_gap, map0_failed;

   assign req_stall  = rsp_valid_ff && rsp_stall && req_last_item;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      held_type_in  = held_type_ff;
      bits_seen_in  = bits_seen_ff;
      fault_seen_in = fault_seen_ff;
      map_in        = map_ff;
      gap_in        = gap_ff;
      if (req_accept) begin
         if (req_first_item) begin
            held_type_in  = req_record_type;
            fault_seen_in = req_range_fault;
            bits_seen_in  = 8'd0;
            for (int i = 0; i < MapWalkers; i++)
               map_in[i] = map_start(1'(i));
            for (int i = 0; i < GapWalkers; i++)
               gap_in[i] = gap_start(3'(i));
         end
         if (!req_carries_no_bit) begin
            if (bits_seen_in != BitsMax)
               bits_seen_in = bits_seen_in + 8'd1;
            if (held_type_in == TypeMap) begin
               for (int i = 0; i < MapWalkers; i++)
                  map_in[i] = map_take(1'(i), req_body_bit, map_in[i]);
            end else if (held_type_in == TypeGap) begin
               for (int i = 0; i < GapWalkers; i++)
                  gap_in[i] = gap_take(3'(i), req_body_bit, gap_in[i]);
            end
         end
      end
   end

   always_comb begin
      pre_ok     = map_in[0].status == ST_COMPLETE;
      trl_ok     = map_in[1].status == ST_COMPLETE;
      mask_in    = 7'd0;
      verdict_in = V_MISMATCH;
      case (held_type_in)
         TypeMap: begin
            if (!fault_seen_in) begin
               if (pre_ok && trl_ok)
                  verdict_in = V_MAP_AMBIG;
               else if (pre_ok)
                  verdict_in = V_PREFIX;
               else if (trl_ok)
                  verdict_in = V_TRAILER;
            end
         end
         TypeGap: begin
            if (!fault_seen_in) begin
               for (int i = 0; i < GapWalkers; i++)
                  mask_in[i] = gap_in[i].status == ST_COMPLETE;
               if (mask_in != 7'd0)
                  verdict_in = ((mask_in & (mask_in - 7'd1)) == 7'd0) ? V_GAP : V_GAP_AMBIG;
            end
         end
         TypeFixed: begin
            if (!fault_seen_in && bits_seen_in == Type4BodyBits)
               verdict_in = V_PARTIAL;
         end
         default: verdict_in = V_UNSUPPORTED;
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || (req_accept && req_last_item);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_type_ff  <= 8'd0;
         bits_seen_ff  <= 8'd0;
         fault_seen_ff <= 1'b0;
         for (int i = 0; i < MapWalkers; i++)
            map_ff[i] <= '0;
         for (int i = 0; i < GapWalkers; i++)
            gap_ff[i] <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         held_type_ff  <= held_type_in;
         bits_seen_ff  <= bits_seen_in;
         fault_seen_ff <= fault_seen_in;
         map_ff        <= map_in;
         gap_ff        <= gap_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_last_item) begin
         rsp_verdict_ff  <= verdict_in;
         rsp_gap_mask_ff <= mask_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_verdict  = rsp_verdict_ff;
   assign rsp_gap_mask = rsp_gap_mask_ff;

   assign rsp_hold     = rsp_valid_ff && rsp_stall;
   assign last_accept  = req_accept && req_last_item;
   assign first_accept = req_accept && req_first_item;
   assign rsp_is_gap   = (rsp_verdict_ff == V_GAP) || (rsp_verdict_ff == V_GAP_AMBIG);
   assign map0_failed  = map_ff[0].status == ST_FAILED;

   `BRSV_ASSERT_NEXT(a_last_gives_result, clock, reset, last_accept, rsp_valid_ff)
   `BRSV_ASSERT_NEXT(a_no_spurious_result, clock, reset, !rsp_hold && !last_accept, !rsp_valid_ff)
   `BRSV_ASSERT_NOW(a_mask_verdict, clock, reset, rsp_valid_ff, (|rsp_gap_mask_ff) == rsp_is_gap)
   `BRSV_ASSERT_NEXT(a_fail_sticky, clock, reset, !first_accept && map0_failed, map0_failed)

endmodule
